FILE: sv/lrb_pkg.sv
// ============================================================================
// Line receive buffer package
// Character codes, result kinds, and the command and status bundles that pass
// between the controller and the datapath.
// ============================================================================
`default_nettype none

package lrb_pkg;

  // Character codes used by the line filter.
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LOW  = 8'h20;
  localparam logic [7:0] CH_HIGH = 8'h7E;
  localparam logic [7:0] CH_SUB  = 8'h58;

  // Input operation codes, carried on the slave tuser.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds, carried on the master tuser.
  localparam logic [1:0] KIND_ECHO  = 2'd0;
  localparam logic [1:0] KIND_MSG   = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Message counter top value.
  localparam int unsigned        CNT_W   = 7;
  localparam logic [CNT_W-1:0]   CNT_MAX = '1;

  // Commands from the controller to the datapath. A received byte that is
  // dropped while overflow is latched needs no command.
  typedef struct packed {
    logic rx_store;   // store and echo a received byte
    logic rd_start;   // begin emitting the oldest line
    logic rd_empty;   // read with nothing pending
    logic load_char;  // move the current stored character to the output
  } lrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;        // output register can take a new result
    logic overflow;        // overflow is latched
    logic nothing_pending; // no complete line and no overflow
    logic char_term;       // current stored character ends the line
  } lrb_status_t;

endpackage

`default_nettype wire

FILE: sv/lrb_ram.sv
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ============================================================================
`default_nettype none

module lrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/lrb_ctrl.sv
// ============================================================================
// Line receive buffer controller
// Accepts input transfers, decodes them into datapath commands and steps
// through a line read one character at a time.
// ============================================================================
`default_nettype none

module lrb_ctrl
  import lrb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic        s_tuser,
  input  wire lrb_status_t status,
  output      lrb_cmd_t    cmd
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t state;
  logic   accept;

  // Input is taken only between lines and while the output can take a result.
  assign s_tready = (state == S_IDLE) && status.out_free;
  assign accept   = s_tvalid && s_tready;

  // Command decode.
  always_comb begin
    cmd           = '0;
    cmd.rx_store  = accept && (s_tuser == OP_RX) && !status.overflow;
    cmd.rd_empty  = accept && (s_tuser == OP_READ) && status.nothing_pending;
    cmd.rd_start  = accept && (s_tuser == OP_READ) && !status.nothing_pending;
    cmd.load_char = (state == S_READ) && status.out_free;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.rd_start) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (cmd.load_char && status.char_term) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/lrb_datapath.sv
// ============================================================================
// Line receive buffer datapath
// Ring indexes, message counter, overflow flag, character filter, the line
// store and the output register.
// ============================================================================
`default_nettype none

module lrb_datapath
  import lrb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  rx_byte,
  input  wire lrb_cmd_t    cmd,
  output      lrb_status_t status,
  input  wire logic        m_tready,
  output      logic        m_tvalid,
  output      logic [1:0]  kind,
  output      logic [7:0]  data_byte,
  output      logic        last_of_run,
  output      logic [5:0]  char_count,
  output      logic [CNT_W-1:0] pending_messages,
  output      logic        overflow_flag
);

  localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BUFFER_DEPTH - 1);

  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] read_index;
  logic [CNT_W-1:0] message_count;
  logic             overflow_latched;
  logic [IDX_W-1:0] char_n;

  logic [IDX_W-1:0] write_index_next;
  logic [IDX_W-1:0] read_index_next;
  logic [IDX_W-1:0] raddr;
  logic [7:0]       rdata;
  logic [7:0]       store_byte;
  logic             rx_is_cr;
  logic             ring_full;
  logic [CNT_W-1:0] rx_count_next;
  logic             out_load;

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx);
    step_index = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  assign write_index_next = step_index(write_index);
  assign read_index_next  = step_index(read_index);

  // Received byte filter; a full ring forces a carriage return.
  assign rx_is_cr  = (rx_byte == CH_CR);
  assign ring_full = (write_index_next == read_index);

  always_comb begin
    if (ring_full || rx_is_cr) begin
      store_byte = CH_CR;
    end else if ((rx_byte < CH_LOW) || (rx_byte > CH_HIGH)) begin
      store_byte = CH_SUB;
    end else begin
      store_byte = rx_byte;
    end
  end

  // A received carriage return counts one more line, saturating at the top.
  assign rx_count_next = (rx_is_cr && (message_count != CNT_MAX)) ?
                         message_count + 1'b1 : message_count;

  // The read address moves ahead only when the current character is taken.
  assign raddr = cmd.load_char ? read_index_next : read_index;

  lrb_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.rx_store),
    .waddr (write_index),
    .wdata (store_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status toward the controller.
  assign status.out_free        = !m_tvalid || m_tready;
  assign status.overflow        = overflow_latched;
  assign status.nothing_pending = (message_count == '0) && !overflow_latched;
  assign status.char_term       = (rdata == CH_CR) || (char_n == IDX_LAST);

  // Buffer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index      <= '0;
      read_index       <= '0;
      message_count    <= '0;
      overflow_latched <= 1'b0;
      char_n           <= '0;
    end else begin
      if (cmd.rx_store) begin
        write_index   <= write_index_next;
        message_count <= rx_count_next;
        if (ring_full) begin
          overflow_latched <= 1'b1;
        end
      end
      if (cmd.rd_start) begin
        if (message_count != '0) begin
          message_count <= message_count - 1'b1;
        end
        overflow_latched <= 1'b0;
        char_n           <= '0;
      end
      if (cmd.load_char) begin
        read_index <= read_index_next;
        char_n     <= char_n + 1'b1;
      end
    end
  end

  assign out_load = cmd.rx_store || cmd.rd_empty || cmd.load_char;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output payload; counter and flag show the state after the step.
  always_ff @(posedge clk) begin
    if (cmd.rx_store) begin
      kind             <= KIND_ECHO;
      data_byte        <= store_byte;
      last_of_run      <= 1'b1;
      char_count       <= '0;
      pending_messages <= rx_count_next;
      overflow_flag    <= overflow_latched || ring_full;
    end else if (cmd.rd_empty) begin
      kind             <= KIND_EMPTY;
      data_byte        <= '0;
      last_of_run      <= 1'b1;
      char_count       <= '0;
      pending_messages <= message_count;
      overflow_flag    <= overflow_latched;
    end else if (cmd.load_char) begin
      kind             <= KIND_MSG;
      data_byte        <= status.char_term ? 8'd0 : rdata;
      last_of_run      <= status.char_term;
      char_count       <= status.char_term ? 6'(char_n) : 6'd0;
      pending_messages <= message_count;
      overflow_flag    <= overflow_latched;
    end
  end

endmodule

`default_nettype wire

FILE: sv/uart_line_receive_buffer.sv
// ============================================================================
// UART line receive buffer
// Timing: a received byte is echoed via the output register; a read passes the
// state register and the output register before its first character, then
// gives one per cycle while the output is not stalled. Throughput: one received
// byte per cycle while the output can take a result; a read stalls the input
// until its line is emitted, paced by the registered store port and output stalls.
// Reset clears indexes, counter, overflow and output valid; no clearing pass.
// Collects received characters into carriage-return-terminated lines in a
// ring buffer, echoes each stored byte and emits the oldest line on request.
// ============================================================================
`default_nettype none

module uart_line_receive_buffer
  import lrb_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] operation
  // Output stream
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,   // [7:0] data_byte, [13:8] char_count,
                                      // [20:14] pending_messages,
                                      // [21] overflow_flag, [23:22] zero
  output      logic [1:0]  m_tuser,   // [1:0] kind
  output      logic        m_tlast    // last_of_run
);

  lrb_cmd_t         cmd;
  lrb_status_t      status;
  logic [7:0]       data_byte;
  logic [5:0]       char_count;
  logic [CNT_W-1:0] pending_messages;
  logic             overflow_flag;

  lrb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  lrb_datapath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .rx_byte          (s_tdata),
    .cmd              (cmd),
    .status           (status),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .kind             (m_tuser),
    .data_byte        (data_byte),
    .last_of_run      (m_tlast),
    .char_count       (char_count),
    .pending_messages (pending_messages),
    .overflow_flag    (overflow_flag)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {2'b00, overflow_flag, pending_messages, char_count, data_byte};

endmodule

`default_nettype wire
